// ===== hw/rtl/stf_pkg.sv =====
// ----------------------------------------------------------------------------
// stf_pkg: shared types, constants and table builders
// Item and result records passed between the front, queue and back parts of
// the scroll tile engine, plus the residue tables used for slot wrapping.
// ----------------------------------------------------------------------------
package stf_pkg;

   localparam int GRID_SIDE_DEF = 9;
   localparam int SLOT_W        = 4;    // wide enough for any grid side up to 16
   localparam int CELL_W        = 8;    // wide enough for 16 x 16 cells
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = 1;
   localparam int QCNT_W        = 2;

   localparam logic [15:0] CACHE_RESET = 16'hFFFF;

   localparam logic CMD_ADDRESS = 1'b0;
   localparam logic CMD_DATA    = 1'b1;

   typedef logic [255:0][SLOT_W-1:0] mod_tab_type;
   typedef logic [7:0][SLOT_W-1:0]   hi_tab_type;

   typedef struct packed {
      logic              command;
      logic [CELL_W-1:0] cell_idx;
      logic [SLOT_W-1:0] slot_x;
      logic [SLOT_W-1:0] slot_y;
      logic [15:0]       pair;
      logic [15:0]       fetch_address;
      logic [9:0]        copy_scroll_x;
      logic [9:0]        copy_scroll_y;
   } stf_item_type;

   typedef struct packed {
      logic [15:0] fetch_address;
      logic        redraw;
      logic [8:0]  tile_code;
      logic [3:0]  palette_select;
      logic        mirror_x;
      logic        mirror_y;
      logic [8:0]  dest_x;
      logic [8:0]  dest_y;
      logic [9:0]  copy_scroll_x;
      logic [9:0]  copy_scroll_y;
   } stf_rsp_type;

   // v mod g for every 8-bit v, built by counting
   function automatic mod_tab_type build_mod_tab(input int g);
      mod_tab_type tab;
      int          r;
      r = 0;
      for (int i = 0; i < 256; i++) begin
         tab[i] = SLOT_W'(r);
         r = r + 1;
         if (r == g) begin
            r = 0;
         end
      end
      return tab;
   endfunction

   // (h * 256) mod g for the three high bits of the coarse vertical scroll
   function automatic hi_tab_type build_hi_tab(input int g);
      hi_tab_type tab;
      int         r;
      r = 0;
      for (int h = 0; h < 8; h++) begin
         tab[h] = SLOT_W'(r);
         for (int j = 0; j < 256; j++) begin
            r = r + 1;
            if (r == g) begin
               r = 0;
            end
         end
      end
      return tab;
   endfunction

endpackage

// ===== hw/rtl/stf_front.sv =====
// ----------------------------------------------------------------------------
// stf_front: request intake and classification
// Decodes a request, works out the map ROM address, the copy scroll offsets
// and the wrapped cache slot, and hands the record to the queue.
// ----------------------------------------------------------------------------
module stf_front import stf_pkg::*; #(
   parameter int GRID_SIDE = GRID_SIDE_DEF
) (
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,
   input  logic         req_tuser,
   input  logic         queue_full,
   output logic         push_valid,
   output stf_item_type push_item
);

   localparam mod_tab_type MOD_TAB = build_mod_tab(GRID_SIDE);
   localparam hi_tab_type  HI_TAB  = build_hi_tab(GRID_SIDE);

   logic [15:0]       scroll_y;
   logic [7:0]        scroll_x;
   logic [3:0]        row;
   logic [3:0]        col;
   logic [7:0]        tile_byte;
   logic [7:0]        attr_byte;
   logic [SLOT_W-1:0] coarse_y_mod;
   logic [SLOT_W-1:0] top;
   logic [SLOT_W-1:0] left;
   logic [SLOT_W-1:0] slot_x;
   logic [SLOT_W-1:0] slot_y;
   logic [14:0]       row_base;
   logic [8:0]        span_x;
   logic [9:0]        span_y;

   assign scroll_y  = req_tdata[15:0];
   assign scroll_x  = req_tdata[23:16];
   assign row       = req_tdata[27:24];
   assign col       = req_tdata[31:28];
   assign tile_byte = req_tdata[39:32];
   assign attr_byte = req_tdata[47:40];

   assign req_tready = !queue_full;
   assign push_valid = req_tvalid && !queue_full;

   // coarse_y is 11 bits: fold the top three bits in through their own table
   assign coarse_y_mod = MOD_TAB[8'({1'b0, MOD_TAB[scroll_y[12:5]]}
                                 + {1'b0, HI_TAB[scroll_y[15:13]]})];
   assign left = MOD_TAB[{5'b0, scroll_x[7:5]}];
   assign top  = SLOT_W'(GRID_SIDE - 1) - coarse_y_mod;

   assign slot_y = MOD_TAB[8'({1'b0, row} + {1'b0, top})];
   assign slot_x = MOD_TAB[8'({1'b0, col} + {1'b0, left})];

   // row base wraps at 15 bits before the column term goes in
   assign row_base = {scroll_y[15:5], 4'b0}
                     + 15'(16 * (GRID_SIDE - 1))
                     + {11'b0, scroll_x[7:5], 1'b0}
                     - (scroll_x[7] ? 15'd16 : 15'd0)
                     - {7'b0, row, 4'b0};

   assign span_x = {left, 5'b0} + {4'b0, scroll_x[4:0]};
   assign span_y = {1'b0, top, 5'b0} + 10'd32 - {5'b0, scroll_y[4:0]};

   always_comb begin
      push_item.command       = req_tuser;
      push_item.cell_idx      = CELL_W'({4'b0, slot_y} * CELL_W'(GRID_SIDE))
                                + {4'b0, slot_x};
      push_item.slot_x        = slot_x;
      push_item.slot_y        = slot_y;
      push_item.pair          = {attr_byte, tile_byte};
      push_item.fetch_address = {1'b0, row_base} + {11'b0, col, 1'b0};
      push_item.copy_scroll_x = 10'd0 - {1'b0, span_x};
      push_item.copy_scroll_y = 10'd0 - span_y;
   end

endmodule

// ===== hw/rtl/stf_queue.sv =====
// ----------------------------------------------------------------------------
// stf_queue: short request queue
// Two-entry first-in first-out buffer between the front and the back part.
// ----------------------------------------------------------------------------
module stf_queue import stf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  stf_item_type push_item,
   output logic         queue_full,
   input  logic         pop_ready,
   output logic         pop_valid,
   output stf_item_type pop_item
);

   stf_item_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              push;
   logic              pop;

   assign queue_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/stf_back.sv =====
// ----------------------------------------------------------------------------
// stf_back: cell cache update and result register
// Reads the cached tile/attribute pair of the request's slot, compares it on
// the next cycle, writes back on a change and builds the redraw result.
// ----------------------------------------------------------------------------
module stf_back import stf_pkg::*; #(
   parameter int GRID_SIDE = GRID_SIDE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   input  stf_item_type pop_item,
   output logic         pop_ready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output stf_rsp_type  rsp_data
);

   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int IDX_W = $clog2(CELLS);

   logic [15:0]      cache_mem [CELLS];
   logic [CELLS-1:0] valid_ff;
   logic [CELLS-1:0] valid_in;
   logic [15:0]      rd_data_ff;
   logic [15:0]      fwd_data_ff;
   logic             fwd_ff;
   logic             fwd_in;
   logic             stage_valid_ff;
   logic             stage_valid_in;
   stf_item_type     stage_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   stf_rsp_type      rsp_ff;
   stf_rsp_type      rsp_in;
   logic             load;
   logic             advance;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] wr_idx;
   logic [15:0]      cached;
   logic             changed;
   logic             write_en;

   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign pop_ready = !stage_valid_ff || advance;
   assign load      = pop_valid && pop_ready;
   assign rd_idx    = pop_item.cell_idx[IDX_W-1:0];
   assign wr_idx    = stage_ff.cell_idx[IDX_W-1:0];

   // a write on the load edge is missed by the read: take it from the bypass
   assign cached   = !valid_ff[wr_idx] ? CACHE_RESET :
                     (fwd_ff ? fwd_data_ff : rd_data_ff);
   assign changed  = (stage_ff.command == CMD_DATA) && (cached != stage_ff.pair);
   assign write_en = advance && changed;
   assign fwd_in   = write_en && (wr_idx == rd_idx);

   always_comb begin
      valid_in = valid_ff;
      if (write_en) begin
         valid_in[wr_idx] = 1'b1;
      end
      stage_valid_in = load ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);
      rsp_valid_in   = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      rsp_in                = '0;
      rsp_in.fetch_address  = stage_ff.fetch_address;
      rsp_in.copy_scroll_x  = stage_ff.copy_scroll_x;
      rsp_in.copy_scroll_y  = stage_ff.copy_scroll_y;
      if (changed) begin
         rsp_in.redraw         = 1'b1;
         rsp_in.tile_code      = {stage_ff.pair[8], stage_ff.pair[7:0]};
         rsp_in.palette_select = stage_ff.pair[13:10];
         rsp_in.mirror_x       = stage_ff.pair[15];
         rsp_in.mirror_y       = stage_ff.pair[14];
         rsp_in.dest_x         = {stage_ff.slot_x, 5'b0};
         rsp_in.dest_y         = {stage_ff.slot_y, 5'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         fwd_ff         <= 1'b0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (load) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         cache_mem[wr_idx] <= stage_ff.pair;
      end
      if (load) begin
         rd_data_ff  <= cache_mem[rd_idx];
         fwd_data_ff <= stage_ff.pair;
         stage_ff    <= pop_item;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== hw/rtl/scroll_tile_fetch_and_cache_top.sv =====
// Throughput: one request per cycle while the response stream is not stalled; the cache
// read is registered and the compare and write-back follow in the next stage, with a
// bypass for back-to-back slots.
// Reset (synchronous): empties the queue and pipeline and clears the cache valid
// bits, so every slot reads as 0xFFFF at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// scroll_tile_fetch_and_cache_top: background scroll tile engine
// Front computes fetch address and slot, a short queue decouples it from the
// back, which keeps the cell cache and issues redraw commands.
// ----------------------------------------------------------------------------
module scroll_tile_fetch_and_cache_top import stf_pkg::*; #(
   parameter int GRID_SIDE = GRID_SIDE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // scroll_y[15:0], scroll_x[23:16], row[27:24], col[31:28],
   // tile_byte[39:32], attr_byte[47:40]
   input  logic [47:0] req_tdata,
   // command[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // fetch_address[15:0], tile_code[24:16], palette_select[28:25], mirror_x[29],
   // mirror_y[30], dest_x[39:31], dest_y[48:40], copy_scroll_x[58:49],
   // copy_scroll_y[68:59], zero[71:69]
   output logic [71:0] rsp_tdata,
   // redraw[0]
   output logic        rsp_tuser
);

   logic         queue_full;
   logic         push_valid;
   stf_item_type push_item;
   logic         pop_valid;
   logic         pop_ready;
   stf_item_type pop_item;
   stf_rsp_type  rsp_data;

   stf_front #(
      .GRID_SIDE (GRID_SIDE)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   stf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .queue_full (queue_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   stf_back #(
      .GRID_SIDE (GRID_SIDE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tuser = rsp_data.redraw;
   assign rsp_tdata = {3'b0,
                       rsp_data.copy_scroll_y,
                       rsp_data.copy_scroll_x,
                       rsp_data.dest_y,
                       rsp_data.dest_x,
                       rsp_data.mirror_y,
                       rsp_data.mirror_x,
                       rsp_data.palette_select,
                       rsp_data.tile_code,
                       rsp_data.fetch_address};

endmodule

// ===== verif/scroll_tile_fetch_and_cache_top_tb.sv =====
// ----------------------------------------------------------------------------
// scroll_tile_fetch_and_cache_top_tb: self-checking bench for the scroll tile engine
// Drives address and data requests through the request stream, models the
// fetch address, copy scroll offsets and the 9 x 9 tile cache in the bench,
// and checks every response in order. The run starts with a directed table,
// then random frames of address/data pairs mixed with noise, under three
// idling profiles on both streams.
// ----------------------------------------------------------------------------
module scroll_tile_fetch_and_cache_top_tb;
   import stf_pkg::*;

   localparam int unsigned GRID        = GRID_SIDE_DEF;
   localparam int          DIR_ROWS    = 21;
   localparam int          RAND_ITEMS  = 1030;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          TAIL_CYCLES = 8;

   typedef struct packed {
      logic        cmd;
      logic [15:0] sy;
      logic [7:0]  sx;
      logic [3:0]  row;
      logic [3:0]  col;
      logic [7:0]  tile;
      logic [7:0]  attr;
      logic        pinned;
      stf_rsp_type want;
   } tile_stim_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;

   logic [15:0]   tile_cache [GRID*GRID];
   stf_rsp_type   tile_rsp_q [$];
   tile_stim_type dir_table [DIR_ROWS];

   int req_count    = 0;
   int rsp_count    = 0;
   int redraw_count = 0;
   int fail_count   = 0;
   int frame_count  = 0;
   int cycle_count  = 0;
   int req_idle_pct  = 31;
   int rsp_stall_pct = 50;

   scroll_tile_fetch_and_cache_top #(
      .GRID_SIDE (GRID_SIDE_DEF)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Fetch address and copy offsets for every request; cache compare and
   // write-back for data requests.
   function automatic stf_rsp_type predict_tile_rsp(input logic cmd, input logic [15:0] sy,
                                                    input logic [7:0] sx,
                                                    input logic [3:0] row, input logic [3:0] col,
                                                    input logic [7:0] tile,
                                                    input logic [7:0] attr);
      stf_rsp_type r;
      int unsigned coarse_y, coarse_x, fine_y, fine_x;
      int unsigned top, left, base, slot_y, slot_x, idx;
      logic [15:0] pair;
      coarse_y = sy[15:5];
      coarse_x = sx[7:5];
      fine_y   = sy[4:0];
      fine_x   = sx[4:0];
      top      = GRID - 1 - (coarse_y % GRID);
      left     = coarse_x % GRID;
      base     = 16 * (coarse_y + GRID - 1) + 2 * coarse_x;
      if (sx[7]) begin
         base = base - 16;
      end
      r = '0;
      // wrap the row base to 15 bits before adding the column term
      r.fetch_address = 16'(((base - 16 * row) & 32'h7FFF) + 2 * col);
      r.copy_scroll_x = 10'(0 - (left * 32 + fine_x));
      r.copy_scroll_y = 10'(0 - (top * 32 + 32 - fine_y));
      if (cmd == CMD_DATA) begin
         slot_y = (row + top) % GRID;
         slot_x = (col + left) % GRID;
         idx    = slot_y * GRID + slot_x;
         pair   = {attr, tile};
         if (tile_cache[idx] != pair) begin
            tile_cache[idx]  = pair;
            r.redraw         = 1'b1;
            r.tile_code      = {attr[0], tile};
            r.palette_select = attr[5:2];
            r.mirror_x       = attr[7];
            r.mirror_y       = attr[6];
            r.dest_x         = 9'(slot_x * 32);
            r.dest_y         = 9'(slot_y * 32);
         end
      end
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_tile_req(input logic cmd, input logic [15:0] sy, input logic [7:0] sx,
                                input logic [3:0] row, input logic [3:0] col,
                                input logic [7:0] tile, input logic [7:0] attr,
                                input logic pinned, input stf_rsp_type want);
      stf_rsp_type pred;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {attr, tile, col, row, sx, sy};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      pred = predict_tile_rsp(cmd, sy, sx, row, col, tile, attr);
      tile_rsp_q.push_back(pinned ? want : pred);
      req_count++;
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles with %0d responses pending", $time,
                  CYCLE_LIMIT, tile_rsp_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      stf_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (rsp_tuser) begin
            redraw_count++;
         end
         if (tile_rsp_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual tdata 0x%h tuser %b",
                     $time, rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = tile_rsp_q.pop_front();
            check_field("fetch_address",  want.fetch_address,  rsp_tdata[15:0]);
            check_field("redraw",         want.redraw,         rsp_tuser);
            check_field("tile_code",      want.tile_code,      rsp_tdata[24:16]);
            check_field("palette_select", want.palette_select, rsp_tdata[28:25]);
            check_field("mirror_x",       want.mirror_x,       rsp_tdata[29]);
            check_field("mirror_y",       want.mirror_y,       rsp_tdata[30]);
            check_field("dest_x",         want.dest_x,         rsp_tdata[39:31]);
            check_field("dest_y",         want.dest_y,         rsp_tdata[48:40]);
            check_field("copy_scroll_x",  want.copy_scroll_x,  rsp_tdata[58:49]);
            check_field("copy_scroll_y",  want.copy_scroll_y,  rsp_tdata[68:59]);
            check_field("tdata pad",      0,                   rsp_tdata[71:69]);
         end
      end
   end

   initial begin
      logic [15:0] sy;
      logic [7:0]  sx, tile, attr;
      logic [3:0]  row, col;
      int          cells, done;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_ADDRESS;
      rsp_tready = 1'b0;
      foreach (tile_cache[i]) begin
         tile_cache[i] = CACHE_RESET;
      end

      // origin scroll; untouched slot meets 0xFF pair, then a real change
      dir_table[0]  = '{CMD_ADDRESS, 16'h0000, 8'h00, 4'd0, 4'd0, 8'h00, 8'h00, 1'b1,
                        '{16'd128, 1'b0, 9'd0, 4'd0, 1'b0, 1'b0, 9'd0, 9'd0, 10'h000, 10'h2E0}};
      dir_table[1]  = '{CMD_DATA, 16'h0000, 8'h00, 4'd0, 4'd0, 8'hFF, 8'hFF, 1'b1,
                        '{16'd128, 1'b0, 9'd0, 4'd0, 1'b0, 1'b0, 9'd0, 9'd0, 10'h000, 10'h2E0}};
      dir_table[2]  = '{CMD_DATA, 16'h0000, 8'h00, 4'd0, 4'd0, 8'h12, 8'hC5, 1'b1,
                        '{16'd128, 1'b1, 9'h112, 4'd1, 1'b1, 1'b1, 9'd0, 9'd256, 10'h000, 10'h2E0}};
      dir_table[3]  = '{CMD_DATA, 16'h0000, 8'h00, 4'd0, 4'd0, 8'h12, 8'hC5, 1'b0, '0};
      dir_table[4]  = '{CMD_DATA, 16'h0000, 8'h00, 4'd0, 4'd0, 8'hFF, 8'hFF, 1'b0, '0};
      // all-ones scroll, row and column beyond the grid
      dir_table[5]  = '{CMD_ADDRESS, 16'hFFFF, 8'hFF, 4'd15, 4'd15, 8'h00, 8'h00, 1'b1,
                        '{16'd32668, 1'b0, 9'd0, 4'd0, 1'b0, 1'b0, 9'd0, 9'd0, 10'h301, 10'h37F}};
      dir_table[6]  = '{CMD_DATA, 16'hFFFF, 8'hFF, 4'd15, 4'd15, 8'h00, 8'h00, 1'b0, '0};
      dir_table[7]  = '{CMD_DATA, 16'hFFFF, 8'hFF, 4'd15, 4'd15, 8'h00, 8'h00, 1'b0, '0};
      // row base wraps below zero at the top of the map
      dir_table[8]  = '{CMD_ADDRESS, 16'h0000, 8'h80, 4'd15, 4'd8, 8'h00, 8'h00, 1'b0, '0};
      dir_table[9]  = '{CMD_DATA, 16'h0000, 8'h80, 4'd15, 4'd8, 8'hA5, 8'h5A, 1'b0, '0};
      dir_table[10] = '{CMD_DATA, 16'h0120, 8'h3F, 4'd8, 4'd8, 8'h5A, 8'hA5, 1'b0, '0};
      dir_table[11] = '{CMD_DATA, 16'h0120, 8'h3F, 4'd8, 4'd8, 8'h5A, 8'hA5, 1'b0, '0};
      dir_table[12] = '{CMD_DATA, 16'h001F, 8'h1F, 4'd0, 4'd0, 8'hFF, 8'h00, 1'b0, '0};
      dir_table[13] = '{CMD_DATA, 16'h001F, 8'h1F, 4'd0, 4'd0, 8'h00, 8'hFF, 1'b0, '0};
      dir_table[14] = '{CMD_ADDRESS, 16'h8000, 8'h60, 4'd9, 4'd9, 8'h00, 8'h00, 1'b0, '0};
      dir_table[15] = '{CMD_DATA, 16'h8000, 8'h60, 4'd9, 4'd9, 8'h80, 8'h01, 1'b0, '0};
      dir_table[16] = '{CMD_DATA, 16'h7FE0, 8'hE0, 4'd4, 4'd12, 8'h7F, 8'h3C, 1'b0, '0};
      dir_table[17] = '{CMD_DATA, 16'h7FE0, 8'hE0, 4'd4, 4'd12, 8'h7F, 8'h40, 1'b0, '0};
      dir_table[18] = '{CMD_ADDRESS, 16'hAAAA, 8'h55, 4'd10, 4'd5, 8'h00, 8'h00, 1'b0, '0};
      dir_table[19] = '{CMD_DATA, 16'h5555, 8'hAA, 4'd5, 4'd10, 8'h55, 8'hAA, 1'b0, '0};
      dir_table[20] = '{CMD_DATA, 16'h5555, 8'hAA, 4'd5, 4'd10, 8'hAA, 8'h55, 1'b0, '0};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_tile_req(dir_table[i].cmd, dir_table[i].sy, dir_table[i].sx, dir_table[i].row,
                       dir_table[i].col, dir_table[i].tile, dir_table[i].attr,
                       dir_table[i].pinned, dir_table[i].want);
      end

      // hold off until the pipeline has drained
      req_tvalid <= 1'b0;
      while (tile_rsp_q.size() != 0) begin
         @(negedge clock);
      end

      while (req_count < DIR_ROWS + RAND_ITEMS) begin
         frame_count++;
         case ($urandom_range(0, 6))
            0:       sy = 16'($urandom_range(0, 511));
            1:       sy = 16'hFFFF - 16'($urandom_range(0, 511));
            default: sy = 16'($urandom);
         endcase
         sx    = 8'($urandom);
         cells = $urandom_range(4, 24);
         for (int c = 0; c < cells; c++) begin
            done = req_count - DIR_ROWS;
            case (done * 3 / RAND_ITEMS)
               0: begin
                  req_idle_pct  = 31;
                  rsp_stall_pct = 50;
               end
               1: begin
                  req_idle_pct  = 50;
                  rsp_stall_pct = 31;
               end
               default: begin
                  req_idle_pct  = 0;
                  rsp_stall_pct = 0;
               end
            endcase
            if ($urandom_range(0, 9) == 0) begin
               // noise: lone request with unrelated fields
               send_tile_req(1'($urandom_range(0, 1)), 16'($urandom), 8'($urandom),
                             4'($urandom), 4'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
            end else begin
               row = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(0, GRID - 1));
               col = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(0, GRID - 1));
               // small pair pool so that cached slots hit again
               if ($urandom_range(0, 9) < 4) begin
                  tile = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  attr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               end else begin
                  tile = 8'($urandom);
                  attr = 8'($urandom);
               end
               send_tile_req(CMD_ADDRESS, sy, sx, row, col, 8'($urandom), 8'($urandom),
                             1'b0, '0);
               send_tile_req(CMD_DATA, sy, sx, row, col, tile, attr, 1'b0, '0);
            end
         end
      end
      req_tvalid <= 1'b0;

      while (tile_rsp_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tile_rsp_q.size() != 0) begin
         $display("%0t: %0d responses never arrived, expected none left, actual %0d",
                  $time, tile_rsp_q.size(), tile_rsp_q.size());
         fail_count++;
      end

      $display("Covered %0d requests (%0d from the table, %0d random frames), %0d responses,",
               req_count, DIR_ROWS, frame_count, rsp_count);
      $display("%0d redraws, under three idling profiles; %0d check failures.",
               redraw_count, fail_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
